@@ rtl/core/hmac_pkg.sv @@
// ----------------------------------------------------------------------------
// HMAC-SHA256 package
// Shared widths, constants, round constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package hmac_pkg;

  localparam int unsigned KeyRegs      = 8;
  localparam int unsigned KeyWidth     = 64;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned CountWidth   = 3;
  localparam int unsigned IndexWidth   = 3;
  localparam int unsigned BlockWords   = 16;
  localparam int unsigned ScheduleBits = 4;

  localparam logic [31:0] IpadWord = 32'h36363636;
  localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
  localparam logic [31:0] PadWord  = 32'h80000000;
  localparam logic [31:0] OuterLen = 32'd768;

  typedef logic [31:0] word_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t v;
    v = '0;
    unique case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = '0;
    endcase
    return v;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/hmac_if.sv @@
// ----------------------------------------------------------------------------
// HMAC stream interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface hmac_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface hmac_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/hmac_ram.sv @@
// ----------------------------------------------------------------------------
// HMAC generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hmac_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/hmac_sha256_stream_core.sv @@
// ----------------------------------------------------------------------------
// HMAC-SHA256 stream core
// Keyed HMAC-SHA256 over a word stream, eight digest words per message.
// ----------------------------------------------------------------------------
// Write the 64-byte key into registers 0..7 while no message is in flight.
// Each message word is first accepted into a holding register and then stored
// in a 16-entry block RAM; once 16 words are stored the block runs one SHA-256
// compression (a load step, 64 rounds at one per cycle and an add step). The
// first word of a message first triggers the ipad block: its 16 words are
// written into the RAM, then one compression. The final word triggers
// padding, up to 16 word writes and one compression per padded block (one or
// two blocks), then the opad block and the outer block, each 16 word writes
// plus one compression; digest words then leave one per cycle as the sink
// takes them. The single round datapath and the per-word store step set the
// rate.
// The schedule lives in a 16-word register window; every RAM entry is written
// before a compression reads it.
`default_nettype none
module hmac_sha256_stream_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [hmac_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire logic [hmac_pkg::KeyWidth-1:0]    cfg_data,
  hmac_msg_if.sink                              msg,
  hmac_dig_if.source                            dig
);
  import hmac_pkg::*;

  // states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KEYW  = 4'd1;  // write key block into RAM
  localparam logic [3:0] S_LOAD  = 4'd2;  // load working vars
  localparam logic [3:0] S_RND   = 4'd3;  // rounds
  localparam logic [3:0] S_ADD   = 4'd4;  // add into chaining value
  localparam logic [3:0] S_PAD   = 4'd5;  // write padding words
  localparam logic [3:0] S_OUT   = 4'd6;  // emit digest
  localparam logic [3:0] S_OUTW  = 4'd7;  // write outer block into RAM

  // what follows a compression
  localparam logic [2:0] N_MSG   = 3'd0;  // back to accepting words
  localparam logic [2:0] N_PAD   = 3'd1;  // continue padding
  localparam logic [2:0] N_OPAD  = 3'd2;  // start opad block
  localparam logic [2:0] N_OUTER = 3'd3;  // start outer digest block
  localparam logic [2:0] N_DONE  = 3'd4;  // emit

  logic [63:0] key [KeyRegs];
  logic [3:0]  state;
  logic [2:0]  nxt;
  logic        key_done;
  logic [3:0]  wpos;
  logic [63:0] bit_len;
  logic [31:0] cv [8];
  logic [31:0] ov [8];
  logic        use_outer;   // compress into outer chaining value
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [6:0]  rnd;
  logic [31:0] win [16];
  logic [4:0]  kcnt;
  logic        pad_len;     // length high word written in this block
  logic        pad_mark;    // pad marker word still owed
  logic        pend_word;   // accepted message word waiting to be stored
  logic [31:0] pend_data;
  logic        pend_last;
  logic [2:0]  pend_cnt;
  logic [2:0]  out_idx;

  // RAM port
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  hmac_ram #(.Width(WordWidth), .Depth(BlockWords)) u_buf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyRegs; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  // key block word for entry kcnt
  logic [63:0] kreg;
  logic [31:0] kword;
  assign kreg  = key[kcnt[3:1]];
  assign kword = (kcnt[0] ? kreg[31:0] : kreg[63:32])
               ^ ((nxt == N_MSG) ? IpadWord : OpadWord);

  // outer block word for entry kcnt: inner digest, marker, zeros, length
  logic [31:0] outer_word;
  always_comb begin
    if (!kcnt[3]) begin
      outer_word = cv[kcnt[2:0]];
    end else if (kcnt[3:0] == 4'd8) begin
      outer_word = PadWord;
    end else if (kcnt[3:0] == 4'd15) begin
      outer_word = OuterLen;
    end else begin
      outer_word = '0;
    end
  end

  // message word after byte masking and pad marker
  logic [2:0]  eff_cnt;
  logic [31:0] last_val;
  always_comb begin
    eff_cnt = (!pend_last || pend_cnt > 3'd4) ? 3'd4 : pend_cnt;
    case (eff_cnt)
      3'd0:    last_val = PadWord;
      3'd1:    last_val = {pend_data[31:24], 24'h800000};
      3'd2:    last_val = {pend_data[31:16], 16'h8000};
      3'd3:    last_val = {pend_data[31:8], 8'h80};
      default: last_val = pend_data;
    endcase
  end

  // round datapath, schedule word from the RAM for the first 16 rounds
  logic [31:0] wt, t1, t2, wnew;
  assign wnew = win[0] + ssig0(win[1]) + win[9] + ssig1(win[14]);
  assign wt   = (rnd < 7'd16) ? ram_rdata : wnew;
  assign t1   = vh + bsig1(ve) + ((ve & vf) ^ (~ve & vg)) + RoundK[rnd[5:0]] + wt;
  assign t2   = bsig0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));

  assign msg.ready = (state == S_IDLE) && !pend_word;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wpos;
    ram_wdata = '0;
    ram_raddr = rnd[3:0] + 4'd1;
    if (state == S_KEYW) begin
      ram_we    = 1'b1;
      ram_waddr = kcnt[3:0];
      ram_wdata = kword;
    end else if (state == S_OUTW) begin
      ram_we    = 1'b1;
      ram_waddr = kcnt[3:0];
      ram_wdata = outer_word;
    end else if (state == S_IDLE && pend_word && key_done) begin
      ram_we    = 1'b1;
      ram_wdata = pend_last ? last_val : pend_data;
    end else if (state == S_PAD) begin
      ram_we = 1'b1;
      if (pad_mark) begin
        ram_wdata = PadWord;
      end else if (wpos == 4'd14) begin
        ram_wdata = bit_len[63:32];
      end else if (wpos == 4'd15 && pad_len) begin
        ram_wdata = bit_len[31:0];
      end
    end else if (state == S_LOAD) begin
      ram_raddr = 4'd0;
    end
  end

  assign dig.valid        = (state == S_OUT);
  assign dig.digest_word  = ov[out_idx];
  assign dig.digest_index = out_idx;
  assign dig.digest_last  = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      nxt       <= N_MSG;
      key_done  <= 1'b0;
      wpos      <= '0;
      bit_len   <= '0;
      pend_word <= 1'b0;
      use_outer <= 1'b0;
      pad_len   <= 1'b0;
      pad_mark  <= 1'b0;
      kcnt      <= '0;
      rnd       <= '0;
      out_idx   <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= init_hash(3'(i));
    end else begin
      unique case (state)
        S_IDLE: begin
          if (msg.valid && msg.ready) begin
            pend_word <= 1'b1;
            pend_data <= msg.message_word;
            pend_last <= msg.last_word;
            pend_cnt  <= msg.valid_bytes;
            if (!key_done) begin
              state <= S_KEYW;
              nxt   <= N_MSG;
              kcnt  <= '0;
              use_outer <= 1'b0;
            end
          end else if (pend_word) begin
            // store the held word
            pend_word <= 1'b0;
            wpos      <= wpos + 4'd1;
            bit_len   <= bit_len + 64'(8 * eff_cnt);
            if (pend_last) begin
              pad_len  <= 1'b0;
              pad_mark <= (eff_cnt == 3'd4);
              if (wpos == 4'd15) begin
                state <= S_LOAD;
                nxt   <= N_PAD;
              end else begin
                state <= S_PAD;
              end
            end else if (wpos == 4'd15) begin
              state <= S_LOAD;
              nxt   <= N_MSG;
            end
          end
        end
        S_KEYW: begin
          kcnt <= kcnt + 5'd1;
          if (kcnt == 5'd15) begin
            state <= S_LOAD;
            if (nxt == N_MSG) begin
              key_done <= 1'b1;
              bit_len  <= 64'd512;
            end
          end
        end
        S_OUTW: begin
          kcnt <= kcnt + 5'd1;
          if (kcnt == 5'd15) state <= S_LOAD;
        end
        S_PAD: begin
          // owed marker, zeros, then the length in entries 14 and 15
          wpos     <= wpos + 4'd1;
          pad_mark <= 1'b0;
          if (!pad_mark && wpos == 4'd14) pad_len <= 1'b1;
          if (wpos == 4'd15) begin
            state <= S_LOAD;
            nxt   <= pad_len ? N_OPAD : N_PAD;
          end
        end
        S_LOAD: begin
          // rounds read the RAM one step ahead
          {va, vb, vc, vd, ve, vf, vg, vh} <= use_outer
            ? {ov[0], ov[1], ov[2], ov[3], ov[4], ov[5], ov[6], ov[7]}
            : {cv[0], cv[1], cv[2], cv[3], cv[4], cv[5], cv[6], cv[7]};
          rnd   <= '0;
          state <= S_RND;
          for (int i = 0; i < 16; i++) win[i] <= '0;
        end
        S_RND: begin
          // shift window, run one round
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= wt;
          {va, vb, vc, vd, ve, vf, vg, vh} <= {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
          rnd <= rnd + 7'd1;
          if (rnd == 7'd63) state <= S_ADD;
        end
        S_ADD: begin
          if (use_outer) begin
            ov[0] <= ov[0] + va; ov[1] <= ov[1] + vb; ov[2] <= ov[2] + vc;
            ov[3] <= ov[3] + vd; ov[4] <= ov[4] + ve; ov[5] <= ov[5] + vf;
            ov[6] <= ov[6] + vg; ov[7] <= ov[7] + vh;
          end else begin
            cv[0] <= cv[0] + va; cv[1] <= cv[1] + vb; cv[2] <= cv[2] + vc;
            cv[3] <= cv[3] + vd; cv[4] <= cv[4] + ve; cv[5] <= cv[5] + vf;
            cv[6] <= cv[6] + vg; cv[7] <= cv[7] + vh;
          end
          unique case (nxt)
            N_MSG: state <= S_IDLE;
            N_PAD: begin
              state <= S_PAD;
            end
            N_OPAD: begin
              for (int i = 0; i < 8; i++) ov[i] <= init_hash(3'(i));
              use_outer <= 1'b1;
              kcnt  <= '0;
              state <= S_KEYW;
              nxt   <= N_OUTER;
            end
            N_OUTER: begin
              kcnt  <= '0;
              state <= S_OUTW;
              nxt   <= N_DONE;
            end
            default: begin
              out_idx <= '0;
              state   <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (dig.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state    <= S_IDLE;
              key_done <= 1'b0;
              wpos     <= '0;
              bit_len  <= '0;
              use_outer <= 1'b0;
              nxt      <= N_MSG;
              for (int i = 0; i < 8; i++) cv[i] <= init_hash(3'(i));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/hmac_checker.sv @@
// ----------------------------------------------------------------------------
// HMAC port checker
// Watches the top-level ports for digest ordering and handshake rules.
// ----------------------------------------------------------------------------
`default_nettype none
module hmac_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        dvalid,
  input wire logic        dready,
  input wire logic [31:0] dword,
  input wire logic [2:0]  dindex,
  input wire logic        dlast,
  input wire logic        mready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dvalid && !dready |=> dvalid && $stable(dword) && $stable(dindex))
    else $error("digest word changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (rst)
    dvalid |-> (dlast == (dindex == 3'd7)))
    else $error("digest_last mismatch");
  a_order: assert property (@(posedge clk) disable iff (rst)
    dvalid && dready && !dlast |=> dvalid && dindex == $past(dindex) + 3'd1)
    else $error("digest words out of order");
  a_noin: assert property (@(posedge clk) disable iff (rst)
    dvalid |-> !mready)
    else $error("input taken during digest output");
endmodule

bind hmac_sha256_stream_core hmac_checker u_chk (
  .clk(clk), .rst(rst), .dvalid(dig.valid), .dready(dig.ready),
  .dword(dig.digest_word), .dindex(dig.digest_index), .dlast(dig.digest_last),
  .mready(msg.ready)
);
`default_nettype wire

@@ tb/hmac_tb_if.sv @@
// ----------------------------------------------------------------------------
// HMAC testbench interface list
// The stream interfaces come from the RTL; this file only holds the register
// index names that the test tasks use.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package hmac_tb_pkg;
  typedef enum logic [2:0] {
    KEY_0_7 = 3'd0, KEY_8_15 = 3'd1, KEY_16_23 = 3'd2, KEY_24_31 = 3'd3,
    KEY_32_39 = 3'd4, KEY_40_47 = 3'd5, KEY_48_55 = 3'd6, KEY_56_63 = 3'd7
  } key_reg_e;
endpackage

@@ tb/hmac_sha256_stream_core_tb.sv @@
// ----------------------------------------------------------------------------
// HMAC-SHA256 stream core testbench
// Streams messages with random lengths, partial last words and keys, predicts
// each digest with a behavioral HMAC-SHA256 and checks every digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module hmac_sha256_stream_core_tb;
  import hmac_pkg::*;
  import hmac_tb_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } digest_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [KeyWidth-1:0] cfg_data = '0;

  hmac_msg_if msg ();
  hmac_dig_if dig ();

  hmac_sha256_stream_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .msg(msg), .dig(dig)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [63:0] key_shadow [8];
  logic [31:0] hash_state [8];
  logic [31:0] blk_words [16];
  int unsigned blk_pos;
  logic [63:0] msg_bits;
  bit ipad_done;
  digest_t digest_q [$];

  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned digests_seen = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  localparam logic [31:0] Kc [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
  localparam logic [31:0] Iv [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one SHA-256 compression of a 16-word block into h
  task automatic sha_compress(ref logic [31:0] h [8], input logic [31:0] b [16]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = b[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + Kc[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] += v[i];
  endtask

  task automatic padded_key(output logic [31:0] b [16], input logic [31:0] pad);
    for (int i = 0; i < 8; i++) begin
      b[2*i]   = key_shadow[i][63:32] ^ pad;
      b[2*i+1] = key_shadow[i][31:0] ^ pad;
    end
  endtask

  task automatic append_word(input logic [31:0] w);
    blk_words[blk_pos] = w;
    blk_pos = (blk_pos + 1) % 16;
    if (blk_pos == 0) sha_compress(hash_state, blk_words);
  endtask

  task automatic clear_digest_state();
    for (int i = 0; i < 8; i++) hash_state[i] = Iv[i];
    blk_pos = 0;
    msg_bits = '0;
    ipad_done = 1'b0;
  endtask

  // advance the HMAC predictor by one accepted word; queue the digest at the end
  task automatic predict_hmac(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    logic [31:0] b [16];
    logic [31:0] outer [8];
    int unsigned n;
    if (!ipad_done) begin
      padded_key(b, IpadWord);
      sha_compress(hash_state, b);
      msg_bits = 64'd512;
      ipad_done = 1'b1;
    end
    n = (cnt > 4 || !lst) ? 4 : cnt;
    if (!lst) begin
      append_word(w);
      msg_bits += 64'd32;
      return;
    end
    if (n == 4) begin
      append_word(w);
      append_word(PadWord);
    end else if (n == 0) begin
      append_word(PadWord);
    end else begin
      append_word((w & (32'hffffffff << (32 - 8*n))) | (PadWord >> (8*n)));
    end
    msg_bits += 64'(8*n);
    if (blk_pos > 14) append_word('0);
    while (blk_pos < 14) append_word('0);
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) outer[i] = Iv[i];
    padded_key(b, OpadWord);
    sha_compress(outer, b);
    for (int i = 0; i < 8; i++) b[i] = hash_state[i];
    b[8] = PadWord;
    for (int i = 9; i < 15; i++) b[i] = '0;
    b[15] = OuterLen;
    sha_compress(outer, b);
    for (int i = 0; i < 8; i++) digest_q.push_back({outer[i], 3'(i), 1'(i == 7)});
    clear_digest_state();
  endtask

  initial begin
    msg.valid = 1'b0;
    msg.message_word = '0;
    msg.valid_bytes = '0;
    msg.last_word = 1'b0;
    dig.ready = 1'b0;
  end

  // receiver: random stall, check each accepted digest word
  always @(posedge clk) begin
    digest_t exp_w;
    if (!rst) begin
      dig.ready <= ($urandom_range(99) >= stall_pct);
      if (dig.valid && dig.ready) begin
        digests_seen++;
        if (digest_q.size() == 0) begin
          $error("digest word with nothing expected: %h", dig.digest_word);
          error_count++;
        end else begin
          exp_w = digest_q.pop_front();
          if (dig.digest_word !== exp_w.digest_word) begin
            $error("digest_word exp %h got %h", exp_w.digest_word, dig.digest_word);
            error_count++;
          end
          if (dig.digest_index !== exp_w.digest_index) begin
            $error("digest_index exp %0d got %0d", exp_w.digest_index, dig.digest_index);
            error_count++;
          end
          if (dig.digest_last !== exp_w.digest_last) begin
            $error("digest_last exp %0d got %0d", exp_w.digest_last, dig.digest_last);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((msg.valid && msg.ready) || (dig.valid && dig.ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // send one word, with a random idle gap first; valid stays up for the next word
  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      msg.valid <= 1'b0;
      @(posedge clk);
    end
    msg.valid <= 1'b1;
    msg.message_word <= w;
    msg.valid_bytes <= cnt;
    msg.last_word <= lst;
    do @(posedge clk); while (!msg.ready);
    predict_hmac(w, cnt, lst);
    words_sent++;
  endtask

  // drop valid and hold until every expected digest word has come
  task automatic wait_digests();
    msg.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key(input key_reg_e idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    key_shadow[idx] = v;
  endtask

  task automatic load_key(input int mode);
    key_reg_e r;
    for (int i = 0; i < 8; i++) begin
      r = key_reg_e'(i);
      case (mode)
        0: write_key(r, '0);
        1: write_key(r, '1);
        default: write_key(r, {$urandom, $urandom});
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // send a message of nwords full words then a last word with cnt bytes
  task automatic send_message(input int nwords, input logic [2:0] cnt);
    for (int i = 0; i < nwords; i++)
      send_word($urandom, 3'($urandom_range(7)), 1'b0);
    send_word($urandom, cnt, 1'b1);
  endtask

  task automatic test_directed();
    load_key(0);
    send_word('0, 3'd0, 1'b1);              // empty message
    send_word(32'hffffffff, 3'd4, 1'b1);
    wait_digests();
    load_key(1);
    send_word(32'hffffffff, 3'd7, 1'b1);     // count above four
    send_word(32'h12345678, 3'd1, 1'b1);
    send_word(32'hdeadbeef, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b1);
    send_word(32'haaaaaaaa, 3'd2, 1'b0);     // partial count on a middle word
    send_word(32'h55555555, 3'd5, 1'b1);
    send_message(13, 3'd3);                  // padding and length still fit in one block
    send_message(14, 3'd0);
    send_message(15, 3'd4);
    wait_digests();
  endtask

  task automatic test_random(input int phase_words);
    int sent;
    sent = 0;
    while (sent < phase_words) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(18);
      send_message(n, 3'($urandom_range(7)));
      sent += n + 1;
      if ($urandom_range(3) == 0) wait_digests();
    end
    wait_digests();
  endtask

  initial begin
    clear_digest_state();
    for (int i = 0; i < 8; i++) key_shadow[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    // random traffic under each idle/stall mix, new key per phase
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 18 : 56) : 0;
      stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 18 : 56) : 0;
      load_key(2);
      test_random(60);
    end
    wait_digests();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d message words, checked %0d digest words over 4 keys + extremes.",
             words_sent, digests_seen);
    if (error_count == 0 && digest_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
